// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rstn, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== src/sas_pkg.sv =====
// Package with the types and constants of the sprite animation sequencer.
package sas_pkg;
    localparam int MaxAnims   = 16;
    localparam int MaxFrames  = 32;
    localparam int AnimW      = $clog2(MaxAnims);
    localparam int FrameW     = $clog2(MaxFrames);
    localparam int AddrW      = AnimW + FrameW;
    localparam int TotalW     = 22;
    localparam int FrecW      = 52;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0, CMD_ADD_ANIM = 3'd1, CMD_ADD_FRAME = 3'd2,
        CMD_INIT = 3'd3, CMD_TICK = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_ZERO_LEN = 3'd2,
        ST_FULL = 3'd3, ST_NO_ANIM = 3'd4
    } status_t;

    // Shared-divider control between sequencer and remainder unit.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [TotalW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [TotalW-1:0] rem;
    } div_rsp_t;
endpackage

// ===== src/sprite_animation_sequencer_unit.sv =====
// Top level of the sprite animation sequencer.
//
//  channel | direction | tdata fields (low bit first)                        | tuser
//  s_      | in        | name_hash, start_offset, frame_ticks, w, h, edge     | cmd
//  m_      | out       | anim_slot, frame_pos, tick_pos, cur_w/h/edge, max_w/h | status
//
// Clear, add animation and add frame run through execute, report and output; tick
// adds a read of the frame memory and a check of the frame's ticks. Init runs a hash
// search over the loaded names, then the bit-serial remainder unit, and then the
// walk, which reads and checks one frame at a time.
// One frame memory port sets the walk's pace.
// Reset is synchronous and active low; the tables stay undefined until written.
// While a result beat waits on m_tready the block takes no new beat.
`include "assert_macros.svh"
module sprite_animation_sequencer_unit import sas_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // name_hash[31:0], start_offset[63:32], frame_ticks[79:64], frame_w[91:80],
    // frame_h[103:92], frame_edge[115:104], zero fill to 120
    input  logic [119:0] s_tdata,
    // cmd[2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // anim_slot[3:0], frame_pos[8:4], tick_pos[24:9], cur_w[36:25], cur_h[48:37],
    // cur_edge[60:49], max_w[72:61], max_h[84:73], zero fill to 88
    output logic [87:0]  m_tdata,
    // status[2:0]
    output logic [2:0]   m_tuser
);
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_EXEC   = 10'b0000000010,
        S_SRCH   = 10'b0000000100,
        S_DIV    = 10'b0000001000,
        S_WREQ   = 10'b0000010000,
        S_WCHK   = 10'b0000100000,
        S_TRD    = 10'b0001000000,
        S_TCHK   = 10'b0010000000,
        S_RPT    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Command latch.
    logic [2:0]   cmd_reg;
    logic [31:0]  hash_reg, offs_reg;
    logic [15:0]  fticks_reg;
    logic [11:0]  fw_reg, fh_reg, fedge_reg;

    // Animation table (16 entries, read at the search, last or active slot).
    logic [31:0]       hashes   [MaxAnims];
    logic [FrameW:0]   fcounts  [MaxAnims];
    logic [TotalW-1:0] totals   [MaxAnims];
    logic [11:0]       mxw      [MaxAnims];
    logic [11:0]       mxh      [MaxAnims];

    logic [AnimW:0]    loaded_reg;
    logic              act_valid_reg;
    logic [AnimW-1:0]  act_anim_reg;
    logic [FrameW-1:0] act_frame_reg;
    logic [15:0]       act_ticks_reg;

    logic [AnimW:0]    idx_reg;     // search index / target slot
    logic [FrameW:0]   wf_reg;      // walk frame counter
    logic [31:0]       rem_reg;     // remaining offset during walk
    logic [2:0]        status_reg;

    // Frame memory.
    logic              fm_we;
    logic [AddrW-1:0]  fm_addr;
    logic [FrecW-1:0]  fm_wdata, fm_rdata;

    div_req_t dreq;
    div_rsp_t drsp;

    logic [87:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_valid_reg;

    sas_ram #(.Width(FrecW), .Depth(MaxAnims * MaxFrames)) u_frames (
        .aclk(aclk), .we(fm_we), .addr(fm_addr), .wdata(fm_wdata), .rdata(fm_rdata)
    );

    sas_rem_unit u_rem (.aclk(aclk), .aresetn(aresetn), .req(dreq), .rsp(drsp));

    logic [AnimW-1:0]  last_a;
    logic [AnimW-1:0]  sidx;
    logic [FrameW:0]   last_n;
    logic [15:0]       rd_ticks;
    logic [15:0]       tick_inc;

    assign last_a   = AnimW'(loaded_reg - 1'b1);
    assign sidx     = idx_reg[AnimW-1:0];
    assign last_n   = fcounts[last_a];
    assign rd_ticks = fm_rdata[15:0];
    assign tick_inc = act_ticks_reg + 16'd1;

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_comb begin
        fm_we    = 1'b0;
        fm_addr  = {act_anim_reg, act_frame_reg};
        fm_wdata = {fedge_reg, fh_reg, fw_reg, fticks_reg};
        if (state_reg == S_EXEC && cmd_reg == CMD_ADD_FRAME && loaded_reg != '0
            && last_n < (FrameW+1)'(MaxFrames)) begin
            fm_we   = 1'b1;
            fm_addr = {last_a, last_n[FrameW-1:0]};
        end else if (state_reg == S_WREQ) begin
            fm_addr = {sidx, wf_reg[FrameW-1:0]};
        end
        dreq.start    = (state_reg == S_DIV) && !drsp.busy && !drsp.done;
        dreq.dividend = offs_reg;
        dreq.divisor  = totals[sidx];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_EXEC;
            S_EXEC: begin
                priority case (cmd_reg)
                    CMD_INIT: state_next = S_SRCH;
                    CMD_TICK: state_next = act_valid_reg ? S_TRD : S_RPT;
                    default:  state_next = S_RPT;
                endcase
            end
            S_SRCH: begin
                if (idx_reg >= loaded_reg) state_next = S_RPT;
                else if (hashes[sidx] == hash_reg)
                    state_next = (totals[sidx] == '0) ? S_RPT : S_DIV;
            end
            S_DIV:  if (drsp.done) state_next = S_WREQ;
            S_WREQ: state_next = (wf_reg >= fcounts[sidx]) ? S_RPT : S_WCHK;
            S_WCHK: state_next = ({16'd0, rd_ticks} > rem_reg) ? S_RPT : S_WREQ;
            S_TRD:  state_next = S_TCHK;
            S_TCHK: state_next = S_RPT;
            S_RPT:  state_next = S_OUT;
            S_OUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            loaded_reg      <= '0;
            act_valid_reg   <= 1'b0;
            act_anim_reg    <= '0;
            act_frame_reg   <= '0;
            act_ticks_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg    <= s_tuser;
                        hash_reg   <= s_tdata[31:0];
                        offs_reg   <= s_tdata[63:32];
                        fticks_reg <= s_tdata[79:64];
                        fw_reg     <= s_tdata[91:80];
                        fh_reg     <= s_tdata[103:92];
                        fedge_reg  <= s_tdata[115:104];
                        status_reg <= ST_OK;
                        idx_reg    <= '0;
                    end
                end
                S_EXEC: begin
                    priority case (cmd_reg)
                        CMD_CLEAR: begin
                            loaded_reg    <= '0;
                            act_valid_reg <= 1'b0;
                            act_anim_reg  <= '0;
                            act_frame_reg <= '0;
                            act_ticks_reg <= '0;
                        end
                        CMD_ADD_ANIM: begin
                            if (loaded_reg >= (AnimW+1)'(MaxAnims)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                hashes[loaded_reg[AnimW-1:0]]  <= hash_reg;
                                fcounts[loaded_reg[AnimW-1:0]] <= '0;
                                totals[loaded_reg[AnimW-1:0]]  <= '0;
                                mxw[loaded_reg[AnimW-1:0]]     <= 12'd1;
                                mxh[loaded_reg[AnimW-1:0]]     <= 12'd1;
                                loaded_reg <= loaded_reg + 1'b1;
                            end
                        end
                        CMD_ADD_FRAME: begin
                            if (loaded_reg == '0) begin
                                status_reg <= ST_NO_ANIM;
                            end else if (last_n >= (FrameW+1)'(MaxFrames)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                fcounts[last_a] <= last_n + 1'b1;
                                totals[last_a]  <= totals[last_a] + TotalW'(fticks_reg);
                                if (fw_reg > mxw[last_a]) mxw[last_a] <= fw_reg;
                                if (fh_reg > mxh[last_a]) mxh[last_a] <= fh_reg;
                            end
                        end
                        CMD_TICK: if (!act_valid_reg) status_reg <= ST_NO_ANIM;
                        default: ;
                    endcase
                end
                S_SRCH: begin
                    if (idx_reg >= loaded_reg) begin
                        status_reg <= ST_NOT_FOUND;
                    end else if (hashes[sidx] == hash_reg) begin
                        if (totals[sidx] == '0) status_reg <= ST_ZERO_LEN;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DIV: begin
                    if (drsp.done) begin
                        rem_reg       <= {{(32-TotalW){1'b0}}, drsp.rem};
                        wf_reg        <= '0;
                        act_valid_reg <= 1'b1;
                        act_anim_reg  <= sidx;
                        act_frame_reg <= '0;
                        act_ticks_reg <= '0;
                    end
                end
                S_WREQ: ;
                S_WCHK: begin
                    if ({16'd0, rd_ticks} > rem_reg) begin
                        act_ticks_reg <= rem_reg[15:0];
                    end else begin
                        act_frame_reg <= act_frame_reg + 1'b1;
                        wf_reg        <= wf_reg + 1'b1;
                        rem_reg       <= rem_reg - {16'd0, rd_ticks};
                    end
                end
                S_TRD: ;
                S_TCHK: begin
                    if (tick_inc >= rd_ticks) begin
                        act_ticks_reg <= '0;
                        if ({1'b0, act_frame_reg} + 1'b1 >= fcounts[act_anim_reg])
                            act_frame_reg <= '0;
                        else
                            act_frame_reg <= act_frame_reg + 1'b1;
                    end else begin
                        act_ticks_reg <= tick_inc;
                    end
                end
                S_RPT: ;
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_user_reg  <= status_reg;
                    if (act_valid_reg) begin
                        out_data_reg <= {3'd0, mxh[act_anim_reg], mxw[act_anim_reg],
                                         fm_rdata[51:40], fm_rdata[39:28], fm_rdata[27:16],
                                         act_ticks_reg, act_frame_reg, act_anim_reg};
                    end else begin
                        out_data_reg <= {3'd0, 12'd1, 12'd1, 36'd0, 16'd0,
                                         {FrameW{1'b0}}, {AnimW{1'b0}}};
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_CLK(a_busy_not_ready, aclk, aresetn, (state_reg != S_IDLE) |-> !s_tready, "ready while busy")
    `ASSERT_CLK(a_loaded_range, aclk, aresetn, loaded_reg <= (AnimW+1)'(MaxAnims), "too many animations")
    `ASSERT_CLK(a_out_after_seq, aclk, aresetn, $rose(out_valid_reg) |-> $past(state_reg) == S_OUT, "beat out of order")
    `ASSERT_CLK(a_active_loaded, aclk, aresetn, act_valid_reg |-> {1'b0, act_anim_reg} < loaded_reg, "active slot not loaded")
endmodule

// ===== src/sas_ram.sv =====
// Generic single-port RAM with registered read.
module sas_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/sas_rem_unit.sv =====
// Bit-serial remainder unit: one quotient bit per cycle.
`include "assert_macros.svh"
module sas_rem_unit import sas_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [31:0]       num_reg, num_next;
    logic [TotalW:0]   rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [TotalW+1:0] shifted;
    logic [TotalW+1:0] diff;

    always_comb begin
        shifted   = {rem_reg, num_reg[31]};
        diff      = shifted - {2'b00, req.divisor};
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start && !busy_reg) begin
            num_next  = req.dividend;
            rem_next  = '0;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            num_next = {num_reg[30:0], 1'b0};
            if (!diff[TotalW+1]) begin
                rem_next = diff[TotalW:0];
            end else begin
                rem_next = shifted[TotalW:0];
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg[TotalW-1:0];

    `ASSERT_CLK(a_done_after_busy, aclk, aresetn, rsp.done |-> $past(busy_reg), "done without run")
    `ASSERT_CLK(a_cnt_zero_idle, aclk, aresetn, !busy_reg |-> cnt_reg == 6'd0, "count left over")
    `ASSERT_CLK(a_rem_below, aclk, aresetn, rsp.done |-> rem_reg < {1'b0, req.divisor}, "remainder too big")
endmodule
